[hw/rtl/multichannel_audio_mixer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Mixer assertion macros
// Shared assertion forms for the mixer checker.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_AUDIO_MIXER_UNIT_DEFINES_SVH
`define MULTICHANNEL_AUDIO_MIXER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MCAM_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication checked in the cycle after its antecedent
`define MCAM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/mcam_pkg.sv]
// ----------------------------------------------------------------------------
// Mixer package
// Word types, codes and constants of the multichannel audio mixer.
// ----------------------------------------------------------------------------
package mcam_pkg;

   localparam int CHANNELS_DEF = 8;

   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_DELAY  = 3'd1;
   localparam logic [2:0] OP_ABORT  = 3'd2;
   localparam logic [2:0] OP_SAMPLE = 3'd3;
   localparam logic [2:0] OP_MIX    = 3'd4;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_GRANTED  = 3'd1;
   localparam logic [2:0] ST_NO_FREE  = 3'd2;
   localparam logic [2:0] ST_FINISHED = 3'd3;
   localparam logic [2:0] ST_RELEASED = 3'd4;
   localparam logic [2:0] ST_MIXED    = 3'd5;
   localparam logic [2:0] ST_IDLE_MIX = 3'd6;

   localparam logic CSR_OUTPUT_ENABLE = 1'b0;
   localparam logic CSR_SAMPLE_RATE   = 1'b1;

   localparam logic        OUTPUT_ENABLE_RESET = 1'b1;
   localparam logic [15:0] SAMPLE_RATE_RESET   = 16'd22050;
   localparam logic [31:0] MS_PER_SECOND       = 32'd1000;
   // divide by 1000: multiply by ceil(2^38 / 1000), keep bits from 38 up
   localparam logic [28:0] DELAY_RECIP         = 29'd274877907;
   localparam int          DELAY_SHIFT         = 38;
   localparam logic [13:0] DELAY_MAX           = 14'd16383;
   localparam logic signed [28:0] MIX_HI       = 29'sd134217727;
   localparam logic signed [28:0] MIX_LO       = -29'sd134217728;
   localparam logic signed [20:0] OUT_HI       = 21'sd32767;
   localparam logic signed [20:0] OUT_LO       = -21'sd32767;
   localparam logic signed [27:0] ROUND_BIAS   = 28'sd127;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [7:0]         slot_tag;
      logic [7:0]         subslot;
      logic [2:0]         channel;
      logic [7:0]         volume_min;
      logic [7:0]         volume_max;
      logic [31:0]        wave_length;
      logic [7:0]         delay_ms;
      logic signed [15:0] sample;
      logic               sample_present;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         out_channel;
      logic [7:0]         owner_tag;
      logic [7:0]         owner_subslot;
      logic signed [15:0] mixed_sample;
   } rsp_type;

   typedef enum logic [2:0] {
      K_START, K_DELAY, K_ABORT, K_SAMPLE, K_MIX, K_NOP
   } kind_type;

   typedef struct packed {
      kind_type kind;
      req_type  req;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

[hw/rtl/mcam_div.sv]
// ----------------------------------------------------------------------------
// Mixer divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcam_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[31]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = 32'(shifted - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/mcam_front.sv]
// ----------------------------------------------------------------------------
// Mixer front end
// Accepts request words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module mcam_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mcam_pkg::req_type       req_payload,
   output mcam_pkg::queue_head_type head,
   input  logic                    pop
);

   mcam_pkg::cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, take;
   mcam_pkg::cmd_type cls;

   always_comb begin
      cls.req = req_payload;
      case (req_payload.opcode)
         mcam_pkg::OP_START:  cls.kind = mcam_pkg::K_START;
         mcam_pkg::OP_DELAY:  cls.kind = mcam_pkg::K_DELAY;
         mcam_pkg::OP_ABORT:  cls.kind = mcam_pkg::K_ABORT;
         mcam_pkg::OP_SAMPLE: cls.kind = mcam_pkg::K_SAMPLE;
         mcam_pkg::OP_MIX:    cls.kind = mcam_pkg::K_MIX;
         default:             cls.kind = mcam_pkg::K_NOP;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign take      = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, take});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

endmodule

[hw/rtl/mcam_back.sv]
// ----------------------------------------------------------------------------
// Mixer back end
// Channel table, sequencer, mix accumulator, configuration and result word.
// ----------------------------------------------------------------------------
module mcam_back #(
   parameter int CHANNELS = mcam_pkg::CHANNELS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mcam_pkg::queue_head_type head,
   output logic                     pop,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [15:0]              csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mcam_pkg::rsp_type        rsp_payload
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_MUL  = 6'b000100,
      S_ACC  = 6'b001000,
      S_DONE = 6'b010000,
      S_RCP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic        play_ff  [CHANNELS], play_in  [CHANNELS];
   logic [13:0] delay_ff [CHANNELS], delay_in [CHANNELS];
   logic        abort_ff [CHANNELS], abort_in [CHANNELS];
   logic [7:0]  tag_ff   [CHANNELS], tag_in   [CHANNELS];
   logic [7:0]  sub_ff   [CHANNELS], sub_in   [CHANNELS];
   logic [31:0] per_ff   [CHANNELS], per_in   [CHANNELS];
   logic [31:0] tmr_ff   [CHANNELS], tmr_in   [CHANNELS];
   logic [7:0]  vol_ff   [CHANNELS], vol_in   [CHANNELS];
   logic [CHANNELS-1:0] busy;

   mcam_pkg::cmd_type  cmd_ff, cmd_in;
   mcam_pkg::rsp_type  res_ff, res_in, rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic signed [27:0] mix_ff, mix_in;
   logic               act_ff, act_in;
   logic signed [24:0] prod_ff, prod_in;
   logic [23:0]        dly_ff, dly_in;
   logic               oe_ff, oe_in;
   logic [15:0]        rate_ff, rate_in;

   logic [IDX_W-1:0]   free_idx, match_idx, ch_idx;
   logic               free_hit, match_hit, ch_hit;
   logic               div_start, div_done;
   logic [31:0]        div_a, div_b, div_q;
   logic signed [28:0] sum29;
   logic signed [27:0] adj;
   logic signed [20:0] q21;
   logic [31:0]        t_next;
   logic [52:0]        rcp;
   logic [14:0]        q15;
   logic [13:0]        d14;
   logic               out_free;

   mcam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      free_idx  = '0;
      free_hit  = 1'b0;
      match_idx = '0;
      match_hit = 1'b0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         busy[c] = play_ff[c] || (delay_ff[c] != 14'd0) || abort_ff[c];
         if (!busy[c]) begin
            free_idx = IDX_W'(c);
            free_hit = 1'b1;
         end
         if (busy[c] && tag_ff[c] == head.cmd.req.slot_tag
               && sub_ff[c] == head.cmd.req.subslot) begin
            match_idx = IDX_W'(c);
            match_hit = 1'b1;
         end
      end
      ch_idx = IDX_W'(head.cmd.req.channel);
      ch_hit = (int'(head.cmd.req.channel) < CHANNELS) && busy[ch_idx];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE);

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         play_in[c]  = play_ff[c];
         delay_in[c] = delay_ff[c];
         abort_in[c] = abort_ff[c];
         tag_in[c]   = tag_ff[c];
         sub_in[c]   = sub_ff[c];
         per_in[c]   = per_ff[c];
         tmr_in[c]   = tmr_ff[c];
         vol_in[c]   = vol_ff[c];
      end
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      cur_in       = cur_ff;
      mix_in       = mix_ff;
      act_in       = act_ff;
      prod_in      = prod_ff;
      dly_in       = dly_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      div_a        = head.cmd.req.wave_length;
      div_b        = 32'(head.cmd.req.volume_max) - 32'(head.cmd.req.volume_min);
      sum29        = 29'(mix_ff) + 29'(prod_ff);
      adj          = mix_ff + (mix_ff[27] ? mcam_pkg::ROUND_BIAS : 28'sd0);
      q21          = 21'(adj >>> 7);
      t_next       = tmr_ff[cur_ff] - 32'd1;
      rcp          = 53'(dly_ff) * 53'(mcam_pkg::DELAY_RECIP);
      q15          = rcp[mcam_pkg::DELAY_SHIFT +: 15];
      d14          = (q15 > 15'(mcam_pkg::DELAY_MAX)) ? mcam_pkg::DELAY_MAX
                                                      : q15[13:0];

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               cmd_in = head.cmd;
               res_in = '0;
               state_in = S_DONE;
               case (head.cmd.kind)
                  mcam_pkg::K_START: begin
                     cur_in = free_idx;
                     if (!free_hit) begin
                        res_in.status = mcam_pkg::ST_NO_FREE;
                     end else if (head.cmd.req.volume_max == head.cmd.req.volume_min) begin
                        play_in[free_idx]  = 1'b1;
                        tag_in[free_idx]   = head.cmd.req.slot_tag;
                        sub_in[free_idx]   = head.cmd.req.subslot;
                        vol_in[free_idx]   = head.cmd.req.volume_min;
                        per_in[free_idx]   = '0;
                        tmr_in[free_idx]   = '0;
                        res_in.status      = mcam_pkg::ST_GRANTED;
                        res_in.out_channel = 3'(free_idx);
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  mcam_pkg::K_DELAY: begin
                     cur_in = free_idx;
                     if (!free_hit) begin
                        res_in.status = mcam_pkg::ST_NO_FREE;
                     end else begin
                        dly_in   = 24'(head.cmd.req.delay_ms) * 24'(rate_ff);
                        state_in = S_RCP;
                     end
                  end
                  mcam_pkg::K_ABORT: begin
                     if (match_hit) begin
                        abort_in[match_idx] = 1'b1;
                     end
                  end
                  mcam_pkg::K_SAMPLE: begin
                     cur_in = ch_idx;
                     if (ch_hit) begin
                        res_in.out_channel = head.cmd.req.channel;
                        if (abort_ff[ch_idx]) begin
                           play_in[ch_idx]  = 1'b0;
                           delay_in[ch_idx] = '0;
                           abort_in[ch_idx] = 1'b0;
                           res_in.status    = mcam_pkg::ST_RELEASED;
                        end else if (delay_ff[ch_idx] != 14'd0) begin
                           delay_in[ch_idx] = delay_ff[ch_idx] - 14'd1;
                           if (delay_ff[ch_idx] == 14'd1) begin
                              res_in.status        = mcam_pkg::ST_FINISHED;
                              res_in.owner_tag     = tag_ff[ch_idx];
                              res_in.owner_subslot = sub_ff[ch_idx];
                           end else begin
                              act_in = 1'b1;
                           end
                        end else if (!head.cmd.req.sample_present) begin
                           play_in[ch_idx]      = 1'b0;
                           res_in.status        = mcam_pkg::ST_FINISHED;
                           res_in.owner_tag     = tag_ff[ch_idx];
                           res_in.owner_subslot = sub_ff[ch_idx];
                        end else begin
                           act_in   = 1'b1;
                           state_in = S_MUL;
                        end
                     end
                  end
                  mcam_pkg::K_MIX: begin
                     if (!act_ff) begin
                        res_in.status = mcam_pkg::ST_IDLE_MIX;
                     end else begin
                        res_in.status = mcam_pkg::ST_MIXED;
                        if (!oe_ff) begin
                           res_in.mixed_sample = '0;
                        end else if (q21 > mcam_pkg::OUT_HI) begin
                           res_in.mixed_sample = 16'(mcam_pkg::OUT_HI);
                        end else if (q21 < mcam_pkg::OUT_LO) begin
                           res_in.mixed_sample = 16'(mcam_pkg::OUT_LO);
                        end else begin
                           res_in.mixed_sample = 16'(q21);
                        end
                     end
                     mix_in = '0;
                     act_in = 1'b0;
                  end
                  default: begin
                     res_in.status = mcam_pkg::ST_DONE;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_in.status      = mcam_pkg::ST_GRANTED;
               res_in.out_channel = 3'(cur_ff);
               play_in[cur_ff]    = 1'b1;
               tag_in[cur_ff]     = cmd_ff.req.slot_tag;
               sub_in[cur_ff]     = cmd_ff.req.subslot;
               vol_in[cur_ff]     = cmd_ff.req.volume_min;
               per_in[cur_ff]     = div_q;
               tmr_in[cur_ff]     = div_q;
               state_in           = S_DONE;
            end
         end
         S_RCP: begin
            res_in.status      = mcam_pkg::ST_GRANTED;
            res_in.out_channel = 3'(cur_ff);
            if (d14 != 14'd0) begin
               tag_in[cur_ff]   = cmd_ff.req.slot_tag;
               sub_in[cur_ff]   = cmd_ff.req.subslot;
               delay_in[cur_ff] = d14;
            end
            state_in = S_DONE;
         end
         S_MUL: begin
            prod_in  = 25'(cmd_ff.req.sample) * 25'($signed({1'b0, vol_ff[cur_ff]}));
            state_in = S_ACC;
         end
         S_ACC: begin
            if (sum29 > mcam_pkg::MIX_HI) begin
               mix_in = 28'(mcam_pkg::MIX_HI);
            end else if (sum29 < mcam_pkg::MIX_LO) begin
               mix_in = 28'(mcam_pkg::MIX_LO);
            end else begin
               mix_in = 28'(sum29);
            end
            if (per_ff[cur_ff] != 32'd0) begin
               if (t_next == 32'd0) begin
                  tmr_in[cur_ff] = per_ff[cur_ff];
                  vol_in[cur_ff] = vol_ff[cur_ff] + 8'd1;
               end else begin
                  tmr_in[cur_ff] = t_next;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   always_comb begin
      oe_in   = oe_ff;
      rate_in = rate_ff;
      if (csr_valid) begin
         case (csr_index)
            mcam_pkg::CSR_OUTPUT_ENABLE: oe_in   = csr_data[0];
            mcam_pkg::CSR_SAMPLE_RATE:   rate_in = csr_data;
            default:                     oe_in   = oe_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mix_ff       <= '0;
         act_ff       <= 1'b0;
         oe_ff        <= mcam_pkg::OUTPUT_ENABLE_RESET;
         rate_ff      <= mcam_pkg::SAMPLE_RATE_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            play_ff[c]  <= 1'b0;
            delay_ff[c] <= '0;
            abort_ff[c] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mix_ff       <= mix_in;
         act_ff       <= act_in;
         oe_ff        <= oe_in;
         rate_ff      <= rate_in;
         for (int c = 0; c < CHANNELS; c++) begin
            play_ff[c]  <= play_in[c];
            delay_ff[c] <= delay_in[c];
            abort_ff[c] <= abort_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      dly_ff  <= dly_in;
      for (int c = 0; c < CHANNELS; c++) begin
         tag_ff[c] <= tag_in[c];
         sub_ff[c] <= sub_in[c];
         per_ff[c] <= per_in[c];
         tmr_ff[c] <= tmr_in[c];
         vol_ff[c] <= vol_in[c];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/multichannel_audio_mixer_unit.sv]
// ----------------------------------------------------------------------------
// Multichannel audio mixer unit
// Channel table with volume ramps, delays, aborts and a saturating mix.
// ----------------------------------------------------------------------------
// Request words enter a two-word queue and are carried out one at a time by
// the back end. Abort, mix out, unknown codes, channel samples that free,
// count down or skip a channel, start sound without a ramp and any start with
// no free channel go straight to the done state; a sample that plays passes
// through multiply, then accumulate. Start sound with a ramp waits for the
// radix-2 divider to form the ramp period; start delay forms the rate product,
// then a reciprocal multiply for the division by 1000. A finished result waits
// in the output register while the queue keeps taking new words until full.
module multichannel_audio_mixer_unit #(
   parameter int CHANNELS = mcam_pkg::CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mcam_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mcam_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [15:0]       csr_data
);

   mcam_pkg::queue_head_type head;
   logic                     pop;

   mcam_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   mcam_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/mcam_checker.sv]
// ----------------------------------------------------------------------------
// Mixer port checker
// Port-level assertions for the mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multichannel_audio_mixer_unit_defines.svh"

module mcam_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mcam_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mcam_pkg::rsp_type rsp_payload,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic              csr_index,
   input logic [15:0]       csr_data
);

   `MCAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "result word dropped or changed under stall")
   `MCAM_ASSERT_IMP(a_mix_only, clock, reset, rsp_valid && rsp_payload.status != mcam_pkg::ST_MIXED, rsp_payload.mixed_sample == 16'sd0, "mixed sample outside mixed status")
   `MCAM_ASSERT_IMP(a_owner_only, clock, reset, rsp_valid && rsp_payload.status != mcam_pkg::ST_FINISHED, rsp_payload.owner_tag == 8'd0 && rsp_payload.owner_subslot == 8'd0, "owner shown outside finished notice")
   `MCAM_ASSERT_IMP(a_no_min, clock, reset, rsp_valid, rsp_payload.mixed_sample != -16'sd32768, "mixed sample not saturated")

endmodule

bind multichannel_audio_mixer_unit mcam_checker u_mcam_checker (.*);

[sim/multichannel_audio_mixer_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multichannel audio mixer unit testbench
// Drives request words through a stall handshake under random bursts, gaps
// and receiver stalls, predicts each response word from its own copy of the
// channel table unless a directed row gives it; compares accepted responses
// field by field. Runs directed rows, then random words per CSR setting.
// ----------------------------------------------------------------------------
module multichannel_audio_mixer_unit_test;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mcam_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mcam_pkg::rsp_type rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = 1'b0;
   logic [15:0]       csr_data = '0;

   multichannel_audio_mixer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   localparam int NCH = mcam_pkg::CHANNELS_DEF;

   // channel table copy
   logic [7:0]  own_tag [NCH];
   logic [7:0]  own_sub [NCH];
   logic        playing [NCH];
   logic [31:0] wait_left [NCH];
   logic [31:0] ramp_len [NCH];
   logic [31:0] ramp_cnt [NCH];
   logic [7:0]  gain [NCH];
   logic        killed [NCH];
   longint      acc_sum;
   logic        acc_live;
   logic        cfg_enable;
   logic [15:0] cfg_rate;

   mcam_pkg::rsp_type pending_rsp [$];
   int      err_count = 0;
   int      accepted = 0;

   typedef struct {
      mcam_pkg::req_type req;
      bit                typed;
      mcam_pkg::rsp_type want;
   } row_type;
   row_type plan [$];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit busy(int c);
      return playing[c] || wait_left[c] != 0 || killed[c];
   endfunction

   function automatic void release_ch(int c);
      playing[c] = 0; wait_left[c] = 0; killed[c] = 0;
      own_tag[c] = 0; own_sub[c] = 0; ramp_len[c] = 0; ramp_cnt[c] = 0;
   endfunction

   function automatic void table_reset();
      for (int c = 0; c < NCH; c++) begin
         release_ch(c);
         gain[c] = 0;
      end
      acc_sum = 0; acc_live = 0;
      cfg_enable = mcam_pkg::OUTPUT_ENABLE_RESET;
      cfg_rate = mcam_pkg::SAMPLE_RATE_RESET;
   endfunction

   function automatic mcam_pkg::rsp_type mix_predict(mcam_pkg::req_type r);
      mcam_pkg::rsp_type o;
      int          f;
      int          c;
      logic [31:0] span;
      logic [31:0] d;
      longint      s;
      o = '0;
      f = -1;
      case (r.opcode)
         mcam_pkg::OP_START, mcam_pkg::OP_DELAY: begin
            for (int k = NCH - 1; k >= 0; k--) if (!busy(k)) f = k;
            if (f < 0) o.status = mcam_pkg::ST_NO_FREE;
            else begin
               c = f;
               o.status = mcam_pkg::ST_GRANTED;
               o.out_channel = 3'(c);
               if (r.opcode == mcam_pkg::OP_START) begin
                  own_tag[c] = r.slot_tag; own_sub[c] = r.subslot;
                  playing[c] = 1; gain[c] = r.volume_min; wait_left[c] = 0;
                  if (r.volume_max != r.volume_min) begin
                     span = 32'(r.volume_max) - 32'(r.volume_min);
                     ramp_len[c] = r.wave_length / span;
                  end else ramp_len[c] = 0;
                  ramp_cnt[c] = ramp_len[c];
               end else begin
                  d = (32'(r.delay_ms) * 32'(cfg_rate)) / mcam_pkg::MS_PER_SECOND;
                  if (d > 32'(mcam_pkg::DELAY_MAX)) d = 32'(mcam_pkg::DELAY_MAX);
                  if (d != 0) begin
                     own_tag[c] = r.slot_tag; own_sub[c] = r.subslot;
                     wait_left[c] = d;
                  end
               end
            end
         end
         mcam_pkg::OP_ABORT: begin
            for (int k = 0; k < NCH; k++)
               if (f < 0 && busy(k) && own_tag[k] == r.slot_tag
                   && own_sub[k] == r.subslot) begin
                  killed[k] = 1;
                  f = k;
               end
         end
         mcam_pkg::OP_SAMPLE: begin
            c = r.channel;
            if (c < NCH && busy(c)) begin
               o.out_channel = 3'(c);
               if (killed[c]) begin
                  release_ch(c);
                  o.status = mcam_pkg::ST_RELEASED;
               end else if (wait_left[c] != 0) begin
                  wait_left[c]--;
                  if (wait_left[c] == 0) begin
                     o.owner_tag = own_tag[c]; o.owner_subslot = own_sub[c];
                     release_ch(c);
                     o.status = mcam_pkg::ST_FINISHED;
                  end else acc_live = 1;
               end else if (!r.sample_present) begin
                  o.owner_tag = own_tag[c]; o.owner_subslot = own_sub[c];
                  release_ch(c);
                  o.status = mcam_pkg::ST_FINISHED;
               end else begin
                  acc_live = 1;
                  acc_sum += longint'(r.sample) * longint'(gain[c]);
                  if (acc_sum > longint'(mcam_pkg::MIX_HI)) acc_sum = mcam_pkg::MIX_HI;
                  else if (acc_sum < longint'(mcam_pkg::MIX_LO)) acc_sum = mcam_pkg::MIX_LO;
                  if (ramp_len[c] != 0) begin
                     ramp_cnt[c]--;
                     if (ramp_cnt[c] == 0) begin
                        ramp_cnt[c] = ramp_len[c];
                        gain[c] = gain[c] + 8'd1;
                     end
                  end
               end
            end
         end
         mcam_pkg::OP_MIX: begin
            if (!acc_live) o.status = mcam_pkg::ST_IDLE_MIX;
            else begin
               s = acc_sum / 128;
               if (s > longint'(mcam_pkg::OUT_HI)) s = mcam_pkg::OUT_HI;
               else if (s < longint'(mcam_pkg::OUT_LO)) s = mcam_pkg::OUT_LO;
               if (!cfg_enable) s = 0;
               o.status = mcam_pkg::ST_MIXED;
               o.mixed_sample = 16'(s);
            end
            acc_sum = 0; acc_live = 0;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic mcam_pkg::rsp_type mk_rsp(logic [2:0] st, logic [2:0] ch);
      mcam_pkg::rsp_type o;
      o = '0;
      o.status = st; o.out_channel = ch;
      return o;
   endfunction

   function automatic void add_row(logic [2:0] op, logic [7:0] tg, logic [7:0] sb,
                                   logic [2:0] ch, logic [7:0] vmin, logic [7:0] vmax,
                                   logic [31:0] len, logic [7:0] dms,
                                   logic [15:0] smp, logic pres, bit typed,
                                   mcam_pkg::rsp_type want);
      row_type w;
      w.req = '{op, tg, sb, ch, vmin, vmax, len, dms, smp, pres};
      w.typed = typed;
      w.want = want;
      plan.push_back(w);
   endfunction

   // random request word, weighted toward well-formed traffic
   function automatic mcam_pkg::req_type make_word();
      mcam_pkg::req_type r;
      logic [127:0]      raw;
      int                pick;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(mcam_pkg::req_type)-1:0];
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
         r.slot_tag = 8'($urandom_range(0, 3));
         r.subslot = 8'($urandom_range(0, 1));
      end
      if (pick < 20) begin
         r.opcode = mcam_pkg::OP_START;
         if ($urandom_range(0, 3) == 0) r.volume_max = r.volume_min;
         if ($urandom_range(0, 1) == 0) r.wave_length = $urandom_range(0, 2000);
      end else if (pick < 28) begin
         r.opcode = mcam_pkg::OP_DELAY;
         if ($urandom_range(0, 15) != 0) r.delay_ms = 8'($urandom_range(0, 1));
      end else if (pick < 38) r.opcode = mcam_pkg::OP_ABORT;
      else if (pick < 88) begin
         r.opcode = mcam_pkg::OP_SAMPLE;
         r.sample_present = ($urandom_range(0, 7) != 0);
      end else if (pick < 98) r.opcode = mcam_pkg::OP_MIX;
      else r.opcode = 3'($urandom_range(5, 7));
      return r;
   endfunction

   task automatic send_word(mcam_pkg::req_type r, bit typed, mcam_pkg::rsp_type want);
      mcam_pkg::rsp_type p;
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      p = mix_predict(r);
      pending_rsp.push_back(typed ? want : p);
      accepted++;
   endtask

   task automatic hold_off(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == mcam_pkg::CSR_OUTPUT_ENABLE) cfg_enable = val[0];
      else cfg_rate = val;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      mcam_pkg::rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response word %h", rsp_payload);
            err_count++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_payload.status !== w.status) begin
               $error("status exp %0d got %0d", w.status, rsp_payload.status);
               err_count++;
            end
            if (rsp_payload.out_channel !== w.out_channel) begin
               $error("out_channel exp %0d got %0d", w.out_channel,
                      rsp_payload.out_channel);
               err_count++;
            end
            if (rsp_payload.owner_tag !== w.owner_tag) begin
               $error("owner_tag exp %0d got %0d", w.owner_tag, rsp_payload.owner_tag);
               err_count++;
            end
            if (rsp_payload.owner_subslot !== w.owner_subslot) begin
               $error("owner_subslot exp %0d got %0d", w.owner_subslot,
                      rsp_payload.owner_subslot);
               err_count++;
            end
            if (rsp_payload.mixed_sample !== w.mixed_sample) begin
               $error("mixed_sample exp %0d got %0d", w.mixed_sample,
                      rsp_payload.mixed_sample);
               err_count++;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold
   initial begin
      int  seg;
      int  mode;
      bit  held;
      held = 0;
      forever begin
         seg = $urandom_range(1, 64);
         mode = $urandom_range(0, 2);
         repeat (seg) begin
            @(negedge clock);
            if (!held && accepted >= 400) begin
               held = 1;
               rsp_stall <= 1'b1;
               repeat (300) @(negedge clock);
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      logic        set_en [4];
      logic [15:0] set_rate [4];
      int          left;
      set_en = '{1'b0, 1'b1, 1'b1, 1'b0};
      set_rate = '{16'd48000, 16'd8000, 16'hFFFF, 16'd0};
      table_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(mcam_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_IDLE_MIX, 0));
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 1, 1,
              mk_rsp(mcam_pkg::ST_DONE, 0));
      add_row(mcam_pkg::OP_START, 8'hFF, 8'hFF, 7, 0, 8'hFF, 32'hFFFFFFFF, 8'hFF,
              16'h8000, 1, 1, mk_rsp(mcam_pkg::ST_GRANTED, 0));
      add_row(mcam_pkg::OP_START, 0, 0, 0, 128, 128, 0, 0, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_GRANTED, 1));
      add_row(mcam_pkg::OP_DELAY, 1, 2, 0, 0, 0, 0, 8'hFF, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_GRANTED, 2));
      add_row(mcam_pkg::OP_DELAY, 3, 3, 0, 0, 0, 0, 0, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_GRANTED, 3));
      add_row(mcam_pkg::OP_START, 4, 5, 0, 200, 10, 100, 0, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_GRANTED, 3));
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 16'h7FFF, 1, 1,
              mk_rsp(mcam_pkg::ST_DONE, 0));
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 1, 0, 0, 0, 0, 16'h8000, 1, 1,
              mk_rsp(mcam_pkg::ST_DONE, 1));
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 3, 0, 0, 0, 0, 16'h7FFF, 1, 0, '0);
      add_row(mcam_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0, '0);
      add_row(mcam_pkg::OP_ABORT, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_DONE, 0));
      add_row(mcam_pkg::OP_ABORT, 9, 9, 0, 0, 0, 0, 0, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_DONE, 0));
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1,
              mk_rsp(mcam_pkg::ST_RELEASED, 0));
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 2, 0, 0, 0, 0, 16'h5555, 1, 0, '0);
      add_row(mcam_pkg::OP_ABORT, 1, 2, 0, 0, 0, 0, 0, 0, 0, 1,
              mk_rsp(mcam_pkg::ST_DONE, 0));
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 2, 0, 0, 0, 0, 0, 1, 1,
              mk_rsp(mcam_pkg::ST_RELEASED, 2));
      add_row(3'd5, 8'hAA, 8'h55, 7, 1, 2, 3, 4, 5, 1, 1, mk_rsp(mcam_pkg::ST_DONE, 0));
      add_row(3'd7, 8'h55, 8'hAA, 7, 1, 2, 3, 4, 5, 1, 1, mk_rsp(mcam_pkg::ST_DONE, 0));
      for (int k = 0; k < 7; k++)
         add_row(mcam_pkg::OP_START, 8'(k), 8'(k), 0, 8'd128, 8'd128, 0, 0, 0, 0, 0, '0);
      add_row(mcam_pkg::OP_SAMPLE, 0, 0, 7, 0, 0, 0, 0, 0, 0, 0, '0);
      add_row(mcam_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);

      foreach (plan[i]) send_word(plan[i].req, plan[i].typed, plan[i].want);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(mcam_pkg::CSR_OUTPUT_ENABLE, {15'd0, set_en[ph]});
         csr_write(mcam_pkg::CSR_SAMPLE_RATE, set_rate[ph]);
         left = 270;
         while (left > 0) begin
            for (int b = $urandom_range(1, 16); b > 0 && left > 0; b--) begin
               send_word(make_word(), 0, '0);
               left--;
            end
            if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 8));
         end
         drain();
      end

      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mcam_pkg.sv
hw/rtl/mcam_div.sv
hw/rtl/mcam_front.sv
hw/rtl/mcam_back.sv
hw/rtl/multichannel_audio_mixer_unit.sv
hw/rtl/mcam_checker.sv
sim/multichannel_audio_mixer_unit_test.sv
